[rtl/lsg_pkg.sv]
// shared constants, types and tables of the lidar sample to pixel block
package lsg_pkg;

    localparam int IMAGE_SIZE   = 512;
    localparam int MAX_SAMPLES  = 4096;
    localparam int PIX_W        = $clog2(IMAGE_SIZE);
    localparam int IDX_W        = 12;
    localparam int RANGE_W      = 16;
    localparam int ANG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 34;
    localparam int TRIG_W       = 17;
    localparam int MAG_W        = RANGE_W + TRIG_W - 2;
    localparam int DW           = MAG_W + 2;
    // divisor of the scale is the maximum range shifted left by this amount
    localparam int SCALE_SH     = 16 - PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_RMIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RMAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd3;

    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER = 34'sd16384;

    localparam logic signed [CW-1:0] ATAN [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
    };

    typedef struct packed {
        logic vld;
        logic rej;
    } t_ctl;

endpackage

[rtl/lsg_if.sv]
// stream interfaces for sample beats in and pixel beats out
interface lsg_in_if;
    logic                           valid;
    logic                           ready;
    logic [lsg_pkg::IDX_W-1:0]      sample_index;
    logic [lsg_pkg::RANGE_W-1:0]    range_mm;
    modport source (output valid, sample_index, range_mm, input ready);
    modport sink (input valid, sample_index, range_mm, output ready);
endinterface

interface lsg_out_if;
    logic                           valid;
    logic                           ready;
    logic [lsg_pkg::PIX_W-1:0]      pixel_x;
    logic [lsg_pkg::PIX_W-1:0]      pixel_y;
    logic [1:0]                     status;
    modport source (output valid, pixel_x, pixel_y, status, input ready);
    modport sink (input valid, pixel_x, pixel_y, status, output ready);
endinterface

[rtl/lsg_front.sv]
// bearing, range check and quadrant fold: two pipeline stages
module lsg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [lsg_pkg::IDX_W-1:0]       i_idx,
    input  logic [lsg_pkg::RANGE_W-1:0]     i_range,
    input  logic [lsg_pkg::RANGE_W-1:0]     i_rmin,
    input  logic [lsg_pkg::RANGE_W-1:0]     i_rmax,
    input  logic [lsg_pkg::ANG_W-1:0]       i_start,
    input  logic [lsg_pkg::ANG_W-1:0]       i_step,
    output lsg_pkg::t_ctl                   o_ctl,
    output logic [lsg_pkg::RANGE_W-1:0]     o_range,
    output logic signed [lsg_pkg::CW-1:0]   o_z,
    output logic                            o_flip
);
    logic [lsg_pkg::IDX_W+lsg_pkg::ANG_W-1:0] w_prod;
    lsg_pkg::t_ctl                  n1_ctl, r1_ctl, r2_ctl;
    logic [lsg_pkg::ANG_W-1:0]      n1_ang, r1_ang;
    logic [lsg_pkg::RANGE_W-1:0]    r1_range, r2_range;
    logic signed [lsg_pkg::ANG_W-1:0] w_a, w_af;
    logic                           w_flip;
    logic signed [lsg_pkg::CW-1:0]  r2_z;
    logic                           r2_flip;

    always_comb begin
        w_prod = (lsg_pkg::IDX_W+lsg_pkg::ANG_W)'(i_idx)
               * (lsg_pkg::IDX_W+lsg_pkg::ANG_W)'(i_step);
        n1_ang = i_start + w_prod[lsg_pkg::ANG_W-1:0];
        n1_ctl.vld = i_vld;
        n1_ctl.rej = (int'(i_idx) >= lsg_pkg::MAX_SAMPLES) || (i_range < i_rmin)
                   || (i_range > i_rmax);
    end

    // fold into a quarter turn either side of zero by toggling the half-turn bit
    always_comb begin
        w_a    = signed'(r1_ang);
        w_flip = (w_a > 16'sd16384) || (w_a < -16'sd16384);
        w_af   = w_flip ? (w_a ^ 16'sh8000) : w_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= n1_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ang   <= n1_ang;
            r1_range <= i_range;
            r2_range <= r1_range;
            r2_z     <= {{(lsg_pkg::CW-lsg_pkg::ANG_W-16){w_af[lsg_pkg::ANG_W-1]}},
                         w_af, 16'h0000};
            r2_flip  <= w_flip;
        end
    end

    assign o_ctl   = r2_ctl;
    assign o_range = r2_range;
    assign o_z     = r2_z;
    assign o_flip  = r2_flip;
endmodule

[rtl/lsg_cordic.sv]
// rotation cordic, one iteration per stage, then rounding to q1.15
module lsg_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  lsg_pkg::t_ctl                       i_ctl,
    input  logic [lsg_pkg::RANGE_W-1:0]         i_range,
    input  logic signed [lsg_pkg::CW-1:0]       i_z,
    input  logic                                i_flip,
    output lsg_pkg::t_ctl                       o_ctl,
    output logic [lsg_pkg::RANGE_W-1:0]         o_range,
    output logic signed [lsg_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [lsg_pkg::TRIG_W-1:0]   o_sin
);
    localparam int N = lsg_pkg::CORDIC_STEPS;

    logic signed [lsg_pkg::CW-1:0]  r_x [N];
    logic signed [lsg_pkg::CW-1:0]  r_y [N];
    logic signed [lsg_pkg::CW-1:0]  r_z [N];
    lsg_pkg::t_ctl                  r_ctl [N];
    logic [lsg_pkg::RANGE_W-1:0]    r_range [N];
    logic                           r_flip [N];

    lsg_pkg::t_ctl                  r_oc;
    logic [lsg_pkg::RANGE_W-1:0]    r_or;
    logic signed [lsg_pkg::TRIG_W-1:0] r_c, r_s;
    logic signed [lsg_pkg::CW-1:0]  w_cr, w_sr;
    logic signed [lsg_pkg::TRIG_W-1:0] w_c, w_s;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [lsg_pkg::CW-1:0] w_xi, w_yi, w_zi;
        lsg_pkg::t_ctl                 w_ci;
        logic [lsg_pkg::RANGE_W-1:0]   w_ri;
        logic                          w_fi;
        if (k == 0) begin : g_first
            assign w_xi = lsg_pkg::CORDIC_GAIN;
            assign w_yi = '0;
            assign w_zi = i_z;
            assign w_ci = i_ctl;
            assign w_ri = i_range;
            assign w_fi = i_flip;
        end else begin : g_next
            assign w_xi = r_x[k-1];
            assign w_yi = r_y[k-1];
            assign w_zi = r_z[k-1];
            assign w_ci = r_ctl[k-1];
            assign w_ri = r_range[k-1];
            assign w_fi = r_flip[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= w_ci;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_zi >= 0) begin
                    r_x[k] <= w_xi - (w_yi >>> k);
                    r_y[k] <= w_yi + (w_xi >>> k);
                    r_z[k] <= w_zi - lsg_pkg::ATAN[k];
                end else begin
                    r_x[k] <= w_xi + (w_yi >>> k);
                    r_y[k] <= w_yi - (w_xi >>> k);
                    r_z[k] <= w_zi + lsg_pkg::ATAN[k];
                end
                r_range[k] <= w_ri;
                r_flip[k]  <= w_fi;
            end
        end
    end

    // round half up to q1.15, negate where the bearing was folded
    always_comb begin
        w_cr = (r_x[N-1] + lsg_pkg::QUARTER) >>> 15;
        w_sr = (r_y[N-1] + lsg_pkg::QUARTER) >>> 15;
        w_c  = w_cr[lsg_pkg::TRIG_W-1:0];
        w_s  = w_sr[lsg_pkg::TRIG_W-1:0];
        if (r_flip[N-1]) begin
            w_c = -w_c;
            w_s = -w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc <= '0;
        end else if (i_en) begin
            r_oc <= r_ctl[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_or <= r_range[N-1];
            r_c  <= w_c;
            r_s  <= w_s;
        end
    end

    assign o_ctl   = r_oc;
    assign o_range = r_or;
    assign o_cos   = r_c;
    assign o_sin   = r_s;
endmodule

[rtl/lsg_scale.sv]
// range times trig, restoring division by the scale, centering and output register
module lsg_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  lsg_pkg::t_ctl                       i_ctl,
    input  logic [lsg_pkg::RANGE_W-1:0]         i_range,
    input  logic signed [lsg_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [lsg_pkg::TRIG_W-1:0]   i_sin,
    input  logic [lsg_pkg::RANGE_W-1:0]         i_rmax,
    output logic                                o_vld,
    output logic [lsg_pkg::PIX_W-1:0]           o_px,
    output logic [lsg_pkg::PIX_W-1:0]           o_py,
    output logic [1:0]                          o_status
);
    localparam int P  = lsg_pkg::PIX_W;
    localparam int MW = lsg_pkg::MAG_W;
    localparam int DW = lsg_pkg::DW;
    localparam int PW = lsg_pkg::TRIG_W + lsg_pkg::RANGE_W;

    logic [lsg_pkg::TRIG_W-1:0]     w_mc, w_ms;
    logic [PW-1:0]                  w_pc, w_ps;
    logic [lsg_pkg::RANGE_W-1:0]    w_rmax;
    logic [DW-1:0]                  w_div;

    lsg_pkg::t_ctl                  r_mctl;
    logic [MW-1:0]                  r_mx, r_my;
    logic                           r_msx, r_msy;

    lsg_pkg::t_ctl                  r_ctl [P];
    logic [MW-1:0]                  r_rx [P];
    logic [MW-1:0]                  r_ry [P];
    logic [P-1:0]                   r_qx [P];
    logic [P-1:0]                   r_qy [P];
    logic                           r_sx [P];
    logic                           r_sy [P];

    logic [P+1:0]                   w_cx, w_cy;
    logic                           w_out;
    logic                           r_vld;
    logic [P-1:0]                   r_px, r_py;
    logic [1:0]                     r_st;

    // magnitude product, sign kept aside for truncation toward zero
    always_comb begin
        w_mc = i_cos[lsg_pkg::TRIG_W-1] ? -i_cos : i_cos;
        w_ms = i_sin[lsg_pkg::TRIG_W-1] ? -i_sin : i_sin;
        w_pc = PW'(i_range) * PW'(w_mc);
        w_ps = PW'(i_range) * PW'(w_ms);
    end

    // a zero maximum is treated as a maximum of one
    always_comb begin
        w_rmax = (i_rmax == '0) ? lsg_pkg::RANGE_W'(1) : i_rmax;
        w_div  = DW'(w_rmax) << lsg_pkg::SCALE_SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mctl <= '0;
        end else if (i_en) begin
            r_mctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx  <= w_pc[MW-1:0];
            r_my  <= w_ps[MW-1:0];
            r_msx <= i_cos[lsg_pkg::TRIG_W-1];
            r_msy <= i_sin[lsg_pkg::TRIG_W-1];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < P; k++) begin : g_div
        localparam int B = P - 1 - k;
        logic [MW-1:0]  w_rxi, w_ryi;
        logic [P-1:0]   w_qxi, w_qyi;
        lsg_pkg::t_ctl  w_ci;
        logic           w_sxi, w_syi;
        logic [DW-1:0]  w_d;
        logic           w_tx, w_ty;
        if (k == 0) begin : g_first
            assign w_rxi = r_mx;
            assign w_ryi = r_my;
            assign w_qxi = '0;
            assign w_qyi = '0;
            assign w_ci  = r_mctl;
            assign w_sxi = r_msx;
            assign w_syi = r_msy;
        end else begin : g_next
            assign w_rxi = r_rx[k-1];
            assign w_ryi = r_ry[k-1];
            assign w_qxi = r_qx[k-1];
            assign w_qyi = r_qy[k-1];
            assign w_ci  = r_ctl[k-1];
            assign w_sxi = r_sx[k-1];
            assign w_syi = r_sy[k-1];
        end
        assign w_d  = w_div << B;
        assign w_tx = DW'(w_rxi) >= w_d;
        assign w_ty = DW'(w_ryi) >= w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= w_ci;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[k]    <= w_tx ? w_rxi - w_d[MW-1:0] : w_rxi;
                r_ry[k]    <= w_ty ? w_ryi - w_d[MW-1:0] : w_ryi;
                r_qx[k]    <= w_qxi | (P'(w_tx) << B);
                r_qy[k]    <= w_qyi | (P'(w_ty) << B);
                r_sx[k]    <= w_sxi;
                r_sy[k]    <= w_syi;
            end
        end
    end

    always_comb begin
        w_cx  = r_sx[P-1] ? (P+2)'(lsg_pkg::IMAGE_SIZE / 2) - (P+2)'(r_qx[P-1])
                          : (P+2)'(lsg_pkg::IMAGE_SIZE / 2) + (P+2)'(r_qx[P-1]);
        w_cy  = r_sy[P-1] ? (P+2)'(lsg_pkg::IMAGE_SIZE / 2) - (P+2)'(r_qy[P-1])
                          : (P+2)'(lsg_pkg::IMAGE_SIZE / 2) + (P+2)'(r_qy[P-1]);
        w_out = (|w_cx[P+1:P]) || (|w_cy[P+1:P]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_ctl[P-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ctl[P-1].rej) begin
                r_st <= lsg_pkg::ST_REJECT;
                r_px <= '0;
                r_py <= '0;
            end else if (w_out) begin
                r_st <= lsg_pkg::ST_OUTSIDE;
                r_px <= '0;
                r_py <= '0;
            end else begin
                r_st <= lsg_pkg::ST_HIT;
                r_px <= w_cx[P-1:0];
                r_py <= w_cy[P-1:0];
            end
        end
    end

    assign o_vld    = r_vld;
    assign o_px     = r_px;
    assign o_py     = r_py;
    assign o_status = r_st;
endmodule

[rtl/laser_scan_to_grid_pixel_core.sv]
// throughput: one beat per cycle while the output side is not stalled;
// the 16-stage cordic and 9-stage divider are fully pipelined
// the whole pipeline holds while the output register waits, so ready follows the output side
// reset (synchronous, active low) empties the pipeline and sets the minimum range 0,
// the maximum range 65535, start angle 0 and angle step 0
module laser_scan_to_grid_pixel_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lsg_in_if.sink                              i_in,
    lsg_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [lsg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lsg_pkg::RANGE_W-1:0]         i_cfg_data
);
    logic [lsg_pkg::RANGE_W-1:0]    r_rmin, r_rmax;
    logic [lsg_pkg::ANG_W-1:0]      r_start, r_step;
    logic                           w_en;

    lsg_pkg::t_ctl                  w_f_ctl, w_c_ctl;
    logic [lsg_pkg::RANGE_W-1:0]    w_f_range, w_c_range;
    logic signed [lsg_pkg::CW-1:0]  w_f_z;
    logic                           w_f_flip;
    logic signed [lsg_pkg::TRIG_W-1:0] w_cos, w_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmin  <= '0;
            r_rmax  <= '1;
            r_start <= '0;
            r_step  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsg_pkg::REG_RMIN:  r_rmin  <= i_cfg_data;
                lsg_pkg::REG_RMAX:  r_rmax  <= i_cfg_data;
                lsg_pkg::REG_START: r_start <= i_cfg_data;
                lsg_pkg::REG_STEP:  r_step  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // advance unless a finished beat is stuck in the output register
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    lsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_idx   (i_in.sample_index),
        .i_range (i_in.range_mm),
        .i_rmin  (r_rmin),
        .i_rmax  (r_rmax),
        .i_start (r_start),
        .i_step  (r_step),
        .o_ctl   (w_f_ctl),
        .o_range (w_f_range),
        .o_z     (w_f_z),
        .o_flip  (w_f_flip)
    );

    lsg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_f_ctl),
        .i_range (w_f_range),
        .i_z     (w_f_z),
        .i_flip  (w_f_flip),
        .o_ctl   (w_c_ctl),
        .o_range (w_c_range),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    lsg_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_c_ctl),
        .i_range  (w_c_range),
        .i_cos    (w_cos),
        .i_sin    (w_sin),
        .i_rmax   (r_rmax),
        .o_vld    (o_out.valid),
        .o_px     (o_out.pixel_x),
        .o_py     (o_out.pixel_y),
        .o_status (o_out.status)
    );

    a_no_pixel_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != lsg_pkg::ST_HIT)
        |-> (o_out.pixel_x == '0) && (o_out.pixel_y == '0))
        else $error("pixel not cleared on a miss");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == lsg_pkg::ST_HIT)
                     || (o_out.status == lsg_pkg::ST_REJECT)
                     || (o_out.status == lsg_pkg::ST_OUTSIDE))
        else $error("bad status code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready out of step with output side");
endmodule

[sim/testbench.sv]
// testbench of the lidar sample to image pixel core: directed and random samples under idling
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [lsg_pkg::PIX_W-1:0] x;
        logic [lsg_pkg::PIX_W-1:0] y;
        logic [1:0]                st;
    } t_pixel;

    localparam longint GAIN_Q30   = 652032874;
    localparam int     DRAIN_CYC  = 40;
    localparam longint CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [lsg_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [lsg_pkg::RANGE_W-1:0]   i_cfg_data;

    lsg_in_if  in_if ();
    lsg_out_if out_if ();

    laser_scan_to_grid_pixel_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the registers
    logic [15:0] rmin_q, rmax_q, start_q, step_q;
    t_pixel pixel_fifo[$];
    int     errors = 0;
    int     send_idle_pct, recv_stall_pct;
    longint cycles = 0;

    longint atan_tbl [16] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cos and sin in q1.15 of a binary angle
    function automatic void bearing_trig(input logic [15:0] ang, output longint c,
                                         output longint s);
        longint a, x, y, z, dx, dy;
        bit flip;
        a = ang;
        flip = 0;
        if (a >= 32768) a -= 65536;
        if (a > 16384) begin
            a -= 32768;
            flip = 1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1;
        end
        z = a * 65536;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tbl[i];
            end else begin
                x += dx; y -= dy; z += atan_tbl[i];
            end
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic t_pixel sample_to_pixel(input logic [lsg_pkg::IDX_W-1:0] idx,
                                               input logic [lsg_pkg::RANGE_W-1:0] rng);
        t_pixel p;
        logic [15:0] ang;
        longint c, s, den, px, py;
        p = '0;
        if (rng < rmin_q || rng > rmax_q) begin
            p.st = lsg_pkg::ST_REJECT;
            return p;
        end
        ang = start_q + idx * step_q;
        bearing_trig(ang, c, s);
        den = 2 * longint'(rmax_q != 0 ? rmax_q : 16'd1) * 32768;
        px = (longint'(rng) * c * lsg_pkg::IMAGE_SIZE) / den + lsg_pkg::IMAGE_SIZE / 2;
        py = (longint'(rng) * s * lsg_pkg::IMAGE_SIZE) / den + lsg_pkg::IMAGE_SIZE / 2;
        if (px < 0 || px >= lsg_pkg::IMAGE_SIZE || py < 0 || py >= lsg_pkg::IMAGE_SIZE) begin
            p.st = lsg_pkg::ST_OUTSIDE;
            return p;
        end
        p.x = px[lsg_pkg::PIX_W-1:0];
        p.y = py[lsg_pkg::PIX_W-1:0];
        p.st = lsg_pkg::ST_HIT;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // receiver side and checking
    always @(posedge i_clk) begin
        t_pixel want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pixel_fifo.size() == 0) begin
                report_mismatch("unexpected beat, status", out_if.status, -1);
            end else begin
                want = pixel_fifo.pop_front();
                if (out_if.status !== want.st) report_mismatch("status", out_if.status, want.st);
                if (out_if.pixel_x !== want.x) report_mismatch("pixel_x", out_if.pixel_x, want.x);
                if (out_if.pixel_y !== want.y) report_mismatch("pixel_y", out_if.pixel_y, want.y);
            end
        end
    end

    task automatic send_sample(input logic [lsg_pkg::IDX_W-1:0] idx,
                               input logic [lsg_pkg::RANGE_W-1:0] rng);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_index <= idx;
        in_if.range_mm     <= rng;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pixel_fifo.insert(pixel_fifo.size(), sample_to_pixel(idx, rng));
    endtask

    task automatic drain;
        in_if.valid <= 1'b0;
        while (pixel_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // write enable stays high across back to back writes, set_scan drops it
    task automatic write_reg(input logic [lsg_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            lsg_pkg::REG_RMIN:  rmin_q = val;
            lsg_pkg::REG_RMAX:  rmax_q = val;
            lsg_pkg::REG_START: start_q = val;
            default:            step_q = val;
        endcase
    endtask

    task automatic set_scan(input logic [15:0] rmin, input logic [15:0] rmax,
                            input logic [15:0] st, input logic [15:0] stp);
        write_reg(lsg_pkg::REG_RMIN, rmin);
        write_reg(lsg_pkg::REG_RMAX, rmax);
        write_reg(lsg_pkg::REG_START, st);
        write_reg(lsg_pkg::REG_STEP, stp);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
    endtask

    // reset values of the registers, full range at bearing zero
    task automatic test_reset_defaults;
        send_sample(12'd0, 16'd0);
        send_sample(12'hfff, 16'hffff);
        send_sample(12'd5, 16'd32768);
        drain();
    endtask

    task automatic test_directed;
        set_scan(16'd100, 16'd1000, 16'h0000, 16'h4000);
        send_sample(12'd0, 16'd1000);   // cosine of one: lands just past the edge
        send_sample(12'd1, 16'd1000);
        send_sample(12'd2, 16'd1000);
        send_sample(12'd3, 16'd1000);
        send_sample(12'd0, 16'd99);     // below minimum
        send_sample(12'd0, 16'd100);
        send_sample(12'd0, 16'd1001);   // above maximum
        send_sample(12'hfff, 16'd500);
        drain();
        // minimum above maximum rejects everything
        set_scan(16'd2000, 16'd1000, 16'h8000, 16'h7fff);
        send_sample(12'd0, 16'd1500);
        send_sample(12'd7, 16'd2000);
        send_sample(12'd9, 16'd1000);
        drain();
        // zero maximum range: only range zero passes
        set_scan(16'd0, 16'd0, 16'h8000, 16'h8000);
        send_sample(12'd0, 16'd0);
        send_sample(12'd1, 16'd1);
        send_sample(12'hfff, 16'd0);
        drain();
        set_scan(16'hffff, 16'hffff, 16'h7fff, 16'h0001);
        send_sample(12'd0, 16'hffff);
        send_sample(12'hfff, 16'hffff);
        send_sample(12'd1, 16'hfffe);
        drain();
    endtask

    task automatic test_random_scans;
        logic [15:0] rmin, rmax, rng;
        int pick;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_scan(16'd0, 16'hffff, 16'h8000, 16'h7fff);
                1: set_scan(16'd0, 16'd1, 16'h7fff, 16'h8000);
                2: set_scan(16'd500, 16'd500, 16'($urandom), 16'($urandom));
                3: set_scan(16'd3000, 16'd255, 16'($urandom), 16'($urandom));
                default: begin
                    rmax = 16'($urandom_range(65535, 1));
                    rmin = 16'($urandom_range(rmax, 0));
                    set_scan(rmin, rmax, 16'($urandom), 16'($urandom));
                end
            endcase
            set_idling(ph % 4);
            for (int n = 0; n < 160; n++) begin
                pick = int'($urandom_range(99));
                if (pick < 70)
                    rng = (rmax_q >= rmin_q) ?
                          16'($urandom_range(rmax_q, rmin_q)) : 16'($urandom);
                else if (pick < 80)
                    rng = rmax_q;
                else if (pick < 85)
                    rng = rmin_q;
                else
                    rng = 16'($urandom);
                send_sample(lsg_pkg::IDX_W'($urandom), rng);
                // idle-free stretch in the middle of each phase
                if (n == 60) set_idling(0);
                if (n == 90) set_idling(ph % 4);
            end
            drain();
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.sample_index = '0;
        in_if.range_mm = '0;
        rmin_q = 16'd0;
        rmax_q = 16'hffff;
        start_q = 16'd0;
        step_q = 16'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_random_scans();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
